// File: src/lar_pkg.sv
// Shared types and constants of the line-assembling receive ring.
package lar_pkg;

  typedef logic [2:0] status_t;
  typedef logic [7:0] byte_t;
  typedef logic [6:0] line_len_t;

  localparam status_t ST_STORED  = 3'd0;
  localparam status_t ST_DROPPED = 3'd1;
  localparam status_t ST_NO_LINE = 3'd2;
  localparam status_t ST_CHAR    = 3'd3;
  localparam status_t ST_END     = 3'd4;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POLL = 1'b1;

  localparam byte_t CHAR_LF = 8'h0A;
  localparam byte_t CHAR_CR = 8'h0D;

  localparam int unsigned RING_DEPTH_DEF = 2048;
  localparam line_len_t   LINE_LEN_RESET = 7'd64;
  localparam line_len_t   LINE_LEN_MAX   = 7'd64;
  localparam line_len_t   LINE_LEN_MIN   = 7'd2;

endpackage

// File: src/lar_if.sv
// Handshake channels of the line-assembling receive ring.
interface lar_req_if import lar_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  req_type;
  byte_t rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface lar_res_if import lar_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  byte_t   line_char;
  logic    last;

  modport source (output valid, output status, output line_char, output last, input ready);
  modport sink   (input valid, input status, input line_char, input last, output ready);
endinterface

interface lar_cfg_if import lar_pkg::*; ();
  logic      valid;
  logic      ready;
  line_len_t max_line_len;

  modport source (output valid, output max_line_len, input ready);
  modport sink   (input valid, input max_line_len, output ready);
endinterface

// File: src/line_assembling_receive_ring_unit.sv
// Line-assembling receive ring: byte ring in one memory, line extraction on request.
// A push result, or the answer to a poll with no complete line held, is registered and
// shown in the cycle after the request is taken. A poll with a line walks the ring through
// the memory's single read port, a read and an evaluate state per held byte up to the
// newline, plus output stalls; the next request is taken after line end.
// Reset empties the ring, clears the newline count and sets the line limit to 64.
module line_assembling_receive_ring_unit import lar_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lar_req_if.sink    req,
  lar_res_if.source  res,
  lar_cfg_if.sink    cfg
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL
  } state_e;

  state_e    state_q;
  logic      out_valid_q;
  status_t   status_q;
  byte_t     char_q;
  logic      last_q;
  logic [AW-1:0] wp_q;
  logic [AW-1:0] rp_q;
  logic [AW-1:0] nl_cnt_q;
  logic [5:0]    cnt_q;
  line_len_t     line_len_q;

  byte_t mem [RING_DEPTH];
  byte_t rd_data_q;

  logic          out_free;
  logic          req_fire;
  logic          mem_we;
  logic          ring_full;
  logic [AW-1:0] wp_next;
  logic [AW-1:0] rp_next;
  line_len_t     lim_eff;
  logic          char_ok;

  assign wp_next   = (wp_q == LAST_IDX) ? '0 : wp_q + 1'b1;
  assign rp_next   = (rp_q == LAST_IDX) ? '0 : rp_q + 1'b1;
  assign ring_full = (wp_next == rp_q);
  assign out_free  = !out_valid_q || res.ready;
  assign req.ready = (state_q == S_IDLE) && out_free;
  assign req_fire  = req.valid && req.ready;
  assign mem_we    = req_fire && (req.req_type == REQ_PUSH) && !ring_full;
  assign lim_eff   = (line_len_q > LINE_LEN_MAX) ? LINE_LEN_MAX : line_len_q;
  assign char_ok   = (rd_data_q != CHAR_CR) && ({1'b0, cnt_q} < (lim_eff - 7'd1));

  assign cfg.ready     = 1'b1;
  assign res.valid     = out_valid_q;
  assign res.status    = status_q;
  assign res.line_char = char_q;
  assign res.last      = last_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wp_q] <= req.rx_byte;
    end
    rd_data_q <= mem[rp_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      status_q    <= ST_STORED;
      char_q      <= '0;
      last_q      <= 1'b0;
      wp_q        <= '0;
      rp_q        <= '0;
      nl_cnt_q    <= '0;
      cnt_q       <= '0;
      line_len_q  <= LINE_LEN_RESET;
    end else begin
      if (cfg.valid) begin
        line_len_q <= cfg.max_line_len;
      end
      if (out_valid_q && res.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            if (req.req_type == REQ_PUSH) begin
              out_valid_q <= 1'b1;
              char_q      <= '0;
              last_q      <= 1'b1;
              if (ring_full) begin
                status_q <= ST_DROPPED;
              end else begin
                status_q <= ST_STORED;
                wp_q     <= wp_next;
                if (req.rx_byte == CHAR_LF) begin
                  nl_cnt_q <= nl_cnt_q + 1'b1;
                end
              end
            end else if ((line_len_q < LINE_LEN_MIN) || (nl_cnt_q == '0)) begin
              out_valid_q <= 1'b1;
              status_q    <= ST_NO_LINE;
              char_q      <= '0;
              last_q      <= 1'b1;
            end else begin
              cnt_q   <= '0;
              state_q <= S_READ;
            end
          end
        end
        S_READ: begin
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          if (rd_data_q == CHAR_LF) begin
            if (out_free) begin
              out_valid_q <= 1'b1;
              status_q    <= ST_END;
              char_q      <= '0;
              last_q      <= 1'b1;
              rp_q        <= rp_next;
              nl_cnt_q    <= nl_cnt_q - 1'b1;
              state_q     <= S_IDLE;
            end
          end else if (char_ok) begin
            if (out_free) begin
              out_valid_q <= 1'b1;
              status_q    <= ST_CHAR;
              char_q      <= rd_data_q;
              last_q      <= 1'b0;
              cnt_q       <= cnt_q + 1'b1;
              rp_q        <= rp_next;
              state_q     <= S_READ;
            end
          end else begin
            rp_q    <= rp_next;
            state_q <= S_READ;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
